/* sv/bilateration_forward_position_defines.svh */
// Assertion macros shared by the bilateration forward position RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef BILATERATION_FORWARD_POSITION_DEFINES_SVH
`define BILATERATION_FORWARD_POSITION_DEFINES_SVH

// Same-cycle implication check.
`define BFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define BFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bfp_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the bilateration forward position block.
// No dependencies; used by the top level.
package bfp_pkg;

    localparam int LEN_W      = 31;  // input length width
    localparam int COORD_W    = 32;  // coordinate width
    localparam int DELTA_W    = 33;  // anchor difference width
    localparam int SPAN_SQ_W  = 64;
    localparam int SPAN_LEN_W = 33;
    localparam int QUO_W      = 63;  // quotient width of the pipelined dividers
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_A_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_A_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_B_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_B_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT  = 3'd5;

endpackage

/* sv/bfp_div_pipe.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; instantiated by the bilateration forward position top level.
module bfp_div_pipe #(
    parameter int QUO_W  = 63,
    parameter int DEN_W  = 33,
    parameter int SIDE_W = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [QUO_W+DEN_W-1:0]   num,
    input  logic [DEN_W-1:0]         den,
    input  logic [SIDE_W-1:0]        side_in,
    output logic                     out_valid,
    output logic [QUO_W-1:0]         quo,
    output logic [SIDE_W-1:0]        side_out
);

    // The numerator must be below den * 2**QUO_W so the top part starts below den.
    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]  low_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];
    logic              v_reg    [QUO_W];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        logic [DEN_W-1:0]  rem_in;
        logic [QUO_W-1:0]  low_in;
        logic [SIDE_W-1:0] side_i;
        logic              v_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign rem_in = num[QUO_W+DEN_W-1:QUO_W];
            assign low_in = num[QUO_W-1:0];
            assign side_i = side_in;
            assign v_in   = in_valid;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign side_i = side_reg[i-1];
            assign v_in   = v_reg[i-1];
        end

        assign trial = {rem_in, low_in[QUO_W-1]};
        assign diff  = trial - {1'b0, den};
        assign ge    = trial >= {1'b0, den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                low_reg[i]  <= {low_in[QUO_W-2:0], ge};
                side_reg[i] <= side_i;
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign quo       = low_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

/* sv/bfp_sqrt_pipe.sv */
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
// Standalone; instantiated by the bilateration forward position top level.
module bfp_sqrt_pipe #(
    parameter int RES_W  = 31,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [2*RES_W-1:0]   rad,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 out_valid,
    output logic [RES_W-1:0]     root,
    output logic [SIDE_W-1:0]    side_out
);

    logic [RES_W+1:0]   rem_reg  [RES_W];
    logic [RES_W-1:0]   root_reg [RES_W];
    logic [2*RES_W-1:0] val_reg  [RES_W];
    logic [SIDE_W-1:0]  side_reg [RES_W];
    logic               v_reg    [RES_W];

    for (genvar i = 0; i < RES_W; i++)
    begin : g_stage
        logic [RES_W+1:0]   rem_in;
        logic [RES_W-1:0]   root_in;
        logic [2*RES_W-1:0] val_in;
        logic [SIDE_W-1:0]  side_i;
        logic               v_in;
        logic [RES_W+3:0]   rem_sh;
        logic [RES_W+3:0]   trial;
        logic [RES_W+3:0]   diff;
        logic               ge;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = rad;
            assign side_i  = side_in;
            assign v_in    = in_valid;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign val_in  = val_reg[i-1];
            assign side_i  = side_reg[i-1];
            assign v_in    = v_reg[i-1];
        end

        assign rem_sh = {rem_in, val_in[2*RES_W-1:2*RES_W-2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign diff   = rem_sh - trial;
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? diff[RES_W+1:0] : rem_sh[RES_W+1:0];
                root_reg[i] <= {root_in[RES_W-2:0], ge};
                val_reg[i]  <= {val_in[2*RES_W-3:0], 2'b00};
                side_reg[i] <= side_i;
            end
        end
    end

    assign out_valid = v_reg[RES_W-1];
    assign root      = root_reg[RES_W-1];
    assign side_out  = side_reg[RES_W-1];

endmodule

/* sv/bilateration_forward_position.sv */
`timescale 1ns / 1ps
// Bilateration forward position: a fully pipelined two-circle intersection solver.
// Depends on bfp_pkg, bfp_div_pipe, bfp_sqrt_pipe and the shared assertion macros.

// The block takes one beat per clock while no recompute runs and the skid entry is
// empty, and returns one result beat per input beat, in order. Its depth is set by
// the chain of three bit-per-stage units: the along-line divider (63 stages), the
// half-chord square root (31 stages) and the four projection dividers (63 stages,
// running side by side), plus the multiply and add stages around them. A one-entry
// skid stage behind the output register lets the pipeline keep taking beats while
// a finished result waits. A configuration write with an index below CFG_REG_COUNT
// starts a recompute of the anchor difference, squared span and span; during that
// time s_tready and cfg_ready stay low. Values are raw signed Q16.16 counts, though
// the arithmetic is exact on the integer counts and does not depend on the fraction
// width. Coincident anchors return anchor A; circles that do not meet give a point
// on the line through the anchors; results saturate to 32 bits.

`include "bilateration_forward_position_defines.svh"

module bilateration_forward_position (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [63:0]                    s_tdata,   // length_from_a[30:0], length_from_b[61:31], zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,   // point_x[31:0], point_y[63:32]
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfp_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Recompute sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DELTA  = 3'd1;
    localparam logic [2:0] ST_MAG    = 3'd2;
    localparam logic [2:0] ST_SQUARE = 3'd3;
    localparam logic [2:0] ST_SUM    = 3'd4;
    localparam logic [2:0] ST_ROOT   = 3'd5;

    localparam int ROOT_STEPS = 33;

    //------------------------------------------------------------------
    // Configuration registers and the recompute sequencer.
    //------------------------------------------------------------------
    logic signed [bfp_pkg::COORD_W-1:0]  anchor_a_x_reg, anchor_a_y_reg;
    logic signed [bfp_pkg::COORD_W-1:0]  anchor_b_x_reg, anchor_b_y_reg;
    logic                                pick_reg;
    logic [2:0]                          state_reg;
    logic [bfp_pkg::DELTA_W-1:0]         dx_reg, dy_reg;
    logic [bfp_pkg::COORD_W-1:0]         mdx_reg, mdy_reg;
    logic [63:0]                         dx2_reg, dy2_reg;
    logic [bfp_pkg::SPAN_SQ_W-1:0]       span_sq_reg;
    logic [bfp_pkg::SPAN_LEN_W-1:0]      span_len_reg;
    logic [65:0]                         rt_val_reg;
    logic [34:0]                         rt_rem_reg;
    logic [32:0]                         rt_root_reg;
    logic [5:0]                          rt_cnt_reg;

    logic        cfg_write;
    logic [64:0] d2_sum;
    logic [36:0] rt_rem_sh, rt_trial, rt_diff;
    logic        rt_ge;
    logic [32:0] rt_root_next;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign cfg_write = cfg_valid && cfg_ready;

    assign d2_sum       = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign rt_rem_sh    = {rt_rem_reg, rt_val_reg[65:64]};
    assign rt_trial     = {2'b00, rt_root_reg, 2'b01};
    assign rt_diff      = rt_rem_sh - rt_trial;
    assign rt_ge        = rt_rem_sh >= rt_trial;
    assign rt_root_next = {rt_root_reg[31:0], rt_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_a_x_reg <= '0;
            anchor_a_y_reg <= '0;
            anchor_b_x_reg <= '0;
            anchor_b_y_reg <= '0;
            pick_reg       <= 1'b0;
            state_reg      <= ST_IDLE;
            dx_reg         <= '0;
            dy_reg         <= '0;
            mdx_reg        <= '0;
            mdy_reg        <= '0;
            dx2_reg        <= '0;
            dy2_reg        <= '0;
            span_sq_reg    <= '0;
            span_len_reg   <= '0;
            rt_val_reg     <= '0;
            rt_rem_reg     <= '0;
            rt_root_reg    <= '0;
            rt_cnt_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_write)
                    begin
                        case (cfg_index)
                            bfp_pkg::CFG_ANCHOR_A_X: anchor_a_x_reg <= cfg_data;
                            bfp_pkg::CFG_ANCHOR_A_Y: anchor_a_y_reg <= cfg_data;
                            bfp_pkg::CFG_ANCHOR_B_X: anchor_b_x_reg <= cfg_data;
                            bfp_pkg::CFG_ANCHOR_B_Y: anchor_b_y_reg <= cfg_data;
                            bfp_pkg::CFG_PICK_HIGH:  pick_reg       <= cfg_data[0];
                            default: ;
                        endcase
                        if (cfg_index < bfp_pkg::CFG_REG_COUNT)
                        begin
                            state_reg <= ST_DELTA;
                        end
                    end
                end
                ST_DELTA:
                begin
                    dx_reg    <= {anchor_b_x_reg[31], anchor_b_x_reg}
                               - {anchor_a_x_reg[31], anchor_a_x_reg};
                    dy_reg    <= {anchor_b_y_reg[31], anchor_b_y_reg}
                               - {anchor_a_y_reg[31], anchor_a_y_reg};
                    state_reg <= ST_MAG;
                end
                ST_MAG:
                begin
                    mdx_reg   <= dx_reg[32] ? (~dx_reg[31:0] + 32'd1) : dx_reg[31:0];
                    mdy_reg   <= dy_reg[32] ? (~dy_reg[31:0] + 32'd1) : dy_reg[31:0];
                    state_reg <= ST_SQUARE;
                end
                ST_SQUARE:
                begin
                    dx2_reg   <= mdx_reg * mdx_reg;
                    dy2_reg   <= mdy_reg * mdy_reg;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    span_sq_reg <= {1'b0, d2_sum[64:2]};
                    rt_val_reg  <= {1'b0, d2_sum};
                    rt_rem_reg  <= '0;
                    rt_root_reg <= '0;
                    rt_cnt_reg  <= 6'(ROOT_STEPS);
                    state_reg   <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    rt_rem_reg  <= rt_ge ? rt_diff[34:0] : rt_rem_sh[34:0];
                    rt_root_reg <= rt_root_next;
                    rt_val_reg  <= {rt_val_reg[63:0], 2'b00};
                    rt_cnt_reg  <= rt_cnt_reg - 6'd1;
                    if (rt_cnt_reg == 6'd1)
                    begin
                        span_len_reg <= rt_root_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // Pipeline enable and input acceptance. The whole pipeline advances
    // unless the skid entry is occupied.
    //------------------------------------------------------------------
    logic en;
    logic skid_v_reg;
    logic [33:0] twod;

    assign en       = !skid_v_reg;
    assign s_tready = en && (state_reg == ST_IDLE);
    assign twod     = {span_len_reg, 1'b0};

    // Stage valids.
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic diva_v, sqrt_v, divx_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_tvalid && s_tready;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= diva_v;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= sqrt_v;
            v8_reg <= divx_v;
            v9_reg <= v8_reg;
        end
    end

    // Stages 0 to 3: capture, squares, numerator of the along-line distance,
    // and its magnitude prepared for a floor division.
    logic [bfp_pkg::LEN_W-1:0] la0_reg, lb0_reg, la1_reg, la2_reg, la3_reg;
    logic [61:0]               sqa1_reg, sqb1_reg, sqa2_reg, sqa3_reg;
    logic signed [66:0]        n2_reg;
    logic [65:0]               num3_reg;
    logic                      neg3_reg;
    logic [66:0]               n2_neg_mag;

    assign n2_neg_mag = 67'd0 - n2_reg + {33'd0, twod} - 67'd1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            la0_reg  <= s_tdata[30:0];
            lb0_reg  <= s_tdata[61:31];
            sqa1_reg <= la0_reg * la0_reg;
            sqb1_reg <= lb0_reg * lb0_reg;
            la1_reg  <= la0_reg;
            n2_reg   <= $signed({5'd0, sqa1_reg}) - $signed({5'd0, sqb1_reg})
                      + $signed({1'b0, span_sq_reg, 2'b00});
            sqa2_reg <= sqa1_reg;
            la2_reg  <= la1_reg;
            neg3_reg <= n2_reg[66];
            num3_reg <= n2_reg[66] ? n2_neg_mag[65:0] : n2_reg[65:0];
            sqa3_reg <= sqa2_reg;
            la3_reg  <= la2_reg;
        end
    end

    // Along-line distance: |a| = floor(|N| / 2D), with the floor bias on negatives.
    logic [bfp_pkg::QUO_W-1:0] qa;
    logic [93:0]               diva_side;

    bfp_div_pipe #(
        .QUO_W  (bfp_pkg::QUO_W),
        .DEN_W  (34),
        .SIDE_W (94)
    ) u_div_along (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .num       ({31'd0, num3_reg}),
        .den       (twod),
        .side_in   ({neg3_reg, sqa3_reg, la3_reg}),
        .out_valid (diva_v),
        .quo       (qa),
        .side_out  (diva_side)
    );

    // Stages 4 to 6: height squared and the along-line projections.
    logic [bfp_pkg::QUO_W-1:0] q4_reg;
    logic                      aneg4_reg, aneg5_reg, aneg6_reg;
    logic                      big4_reg, big5_reg;
    logic [61:0]               sqa4_reg, sqa5_reg, a2_5_reg, rad6_reg;
    logic [63:0]               ppxl_reg, ppyl_reg;
    logic [62:0]               ppxh_reg, ppyh_reg;
    logic [94:0]               pax6_reg, pay6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q4_reg    <= qa;
            aneg4_reg <= diva_side[93];
            sqa4_reg  <= diva_side[92:31];
            big4_reg  <= qa >= {32'd0, diva_side[30:0]};

            a2_5_reg  <= q4_reg[30:0] * q4_reg[30:0];
            ppxl_reg  <= q4_reg[31:0] * mdx_reg;
            ppxh_reg  <= q4_reg[62:32] * mdx_reg;
            ppyl_reg  <= q4_reg[31:0] * mdy_reg;
            ppyh_reg  <= q4_reg[62:32] * mdy_reg;
            aneg5_reg <= aneg4_reg;
            big5_reg  <= big4_reg;
            sqa5_reg  <= sqa4_reg;

            rad6_reg  <= big5_reg ? 62'd0 : (sqa5_reg - a2_5_reg);
            pax6_reg  <= {31'd0, ppxl_reg} + {ppxh_reg, 32'd0};
            pay6_reg  <= {31'd0, ppyl_reg} + {ppyh_reg, 32'd0};
            aneg6_reg <= aneg5_reg;
        end
    end

    // Half chord h = isqrt(La^2 - a^2).
    logic [bfp_pkg::LEN_W-1:0] h_root;
    logic [190:0]              sqrt_side;

    bfp_sqrt_pipe #(
        .RES_W  (bfp_pkg::LEN_W),
        .SIDE_W (191)
    ) u_sqrt_chord (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .rad       (rad6_reg),
        .side_in   ({aneg6_reg, pay6_reg, pax6_reg}),
        .out_valid (sqrt_v),
        .root      (h_root),
        .side_out  (sqrt_side)
    );

    // Stage 7: chord projections.
    logic [62:0] hx7_reg, hy7_reg;
    logic [94:0] pax7_reg, pay7_reg;
    logic        aneg7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx7_reg   <= h_root * mdx_reg;
            hy7_reg   <= h_root * mdy_reg;
            pax7_reg  <= sqrt_side[94:0];
            pay7_reg  <= sqrt_side[189:95];
            aneg7_reg <= sqrt_side[190];
        end
    end

    // Four equal-latency divisions by D.
    logic [bfp_pkg::QUO_W-1:0] qax, qay, qhx, qhy;
    logic                      aneg_out;

    bfp_div_pipe #(
        .QUO_W  (bfp_pkg::QUO_W),
        .DEN_W  (bfp_pkg::SPAN_LEN_W),
        .SIDE_W (1)
    ) u_div_ax (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .num       ({1'b0, pax7_reg}),
        .den       (span_len_reg),
        .side_in   (aneg7_reg),
        .out_valid (divx_v),
        .quo       (qax),
        .side_out  (aneg_out)
    );

    bfp_div_pipe #(
        .QUO_W  (bfp_pkg::QUO_W),
        .DEN_W  (bfp_pkg::SPAN_LEN_W),
        .SIDE_W (1)
    ) u_div_ay (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .num       ({1'b0, pay7_reg}),
        .den       (span_len_reg),
        .side_in   (1'b0),
        .out_valid (),
        .quo       (qay),
        .side_out  ()
    );

    bfp_div_pipe #(
        .QUO_W  (bfp_pkg::QUO_W),
        .DEN_W  (bfp_pkg::SPAN_LEN_W),
        .SIDE_W (1)
    ) u_div_hx (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .num       ({33'd0, hx7_reg}),
        .den       (span_len_reg),
        .side_in   (1'b0),
        .out_valid (),
        .quo       (qhx),
        .side_out  ()
    );

    bfp_div_pipe #(
        .QUO_W  (bfp_pkg::QUO_W),
        .DEN_W  (bfp_pkg::SPAN_LEN_W),
        .SIDE_W (1)
    ) u_div_hy (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .num       ({33'd0, hy7_reg}),
        .den       (span_len_reg),
        .side_in   (1'b0),
        .out_valid (),
        .quo       (qhy),
        .side_out  ()
    );

    // Stage 8 applies the signs (truncation toward zero), stage 9 sums.
    logic [63:0] sax8_reg, say8_reg, shx8_reg, shy8_reg;
    logic [65:0] sumx9_reg, sumy9_reg;
    logic [65:0] ax_ext, ay_ext, sax_ext, say_ext, shx_ext, shy_ext;

    assign ax_ext  = {{34{anchor_a_x_reg[31]}}, anchor_a_x_reg};
    assign ay_ext  = {{34{anchor_a_y_reg[31]}}, anchor_a_y_reg};
    assign sax_ext = {{2{sax8_reg[63]}}, sax8_reg};
    assign say_ext = {{2{say8_reg[63]}}, say8_reg};
    assign shx_ext = {{2{shx8_reg[63]}}, shx8_reg};
    assign shy_ext = {{2{shy8_reg[63]}}, shy8_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sax8_reg <= (aneg_out ^ dx_reg[32]) ? (64'd0 - {1'b0, qax}) : {1'b0, qax};
            say8_reg <= (aneg_out ^ dy_reg[32]) ? (64'd0 - {1'b0, qay}) : {1'b0, qay};
            shx8_reg <= dx_reg[32] ? (64'd0 - {1'b0, qhx}) : {1'b0, qhx};
            shy8_reg <= dy_reg[32] ? (64'd0 - {1'b0, qhy}) : {1'b0, qhy};

            if (span_len_reg == '0)
            begin
                sumx9_reg <= ax_ext;
                sumy9_reg <= ay_ext;
            end
            else if (pick_reg)
            begin
                sumx9_reg <= ax_ext + sax_ext - shy_ext;
                sumy9_reg <= ay_ext + say_ext + shx_ext;
            end
            else
            begin
                sumx9_reg <= ax_ext + sax_ext + shy_ext;
                sumy9_reg <= ay_ext + say_ext - shx_ext;
            end
        end
    end

    // Saturation to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic [65:0] v);
        logic [31:0] r;
        if (v[65:31] == {35{1'b0}} || v[65:31] == {35{1'b1}})
        begin
            r = v[31:0];
        end
        else if (v[65])
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = 32'h7fff_ffff;
        end
        return r;
    endfunction

    //------------------------------------------------------------------
    // Output register with a one-entry skid stage.
    //------------------------------------------------------------------
    logic        out_v_reg;
    logic [63:0] out_data_reg, skid_data_reg;
    logic [63:0] result;
    logic        taken, incoming;

    assign result   = {sat32(sumy9_reg), sat32(sumx9_reg)};
    assign taken    = out_v_reg && m_tready;
    assign incoming = en && v9_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (taken)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (incoming)
        begin
            if (out_v_reg && !taken)
            begin
                skid_v_reg <= 1'b1;
            end
            out_v_reg <= 1'b1;
        end
        else if (taken)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (taken)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (incoming)
        begin
            if (out_v_reg && !taken)
            begin
                skid_data_reg <= result;
            end
            else
            begin
                out_data_reg <= result;
            end
        end
    end

    //------------------------------------------------------------------
    // Assertions.
    //------------------------------------------------------------------
    `BFP_ASSERT_NOW(a_skid_behind_output, skid_v_reg, out_v_reg, "skid entry held without an output beat")
    `BFP_ASSERT_NOW(a_no_input_in_recompute, state_reg != ST_IDLE, !s_tready, "input taken during recompute")
    `BFP_ASSERT_NEXT(a_write_starts_recompute, cfg_write && (cfg_index < bfp_pkg::CFG_REG_COUNT), state_reg == ST_DELTA, "register write did not start recompute")

endmodule
